@@ sv/q2e_pkg.sv @@
`default_nettype none
// shared types, widths, pipeline timing and arithmetic helpers
// for the quaternion to euler converter; no dependencies
package q2e_pkg;

  // number formats
  localparam int FRAC_BITS    = 15;
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_FRAC   = 16;
  localparam int COMP_W       = 16;
  localparam int THR_W        = 15;
  localparam int BANK_W       = 9;
  localparam int HEAD_W       = 10;
  localparam int ATT_W        = 8;
  localparam int POLE_W       = 2;

  localparam int PROD_W    = 2 * COMP_W;
  localparam int TEST_W    = PROD_W + 1;
  localparam int ONE_SHIFT = 2 * FRAC_BITS;
  localparam int V_W       = ONE_SHIFT + 1;
  localparam int RAD_MSB   = 2 * ONE_SHIFT;
  localparam int RAD_W     = RAD_MSB + 2;
  localparam int SQRT_STEPS = RAD_MSB / 2 + 1;

  // angle and cordic datapath
  localparam int ANG_W      = 26;
  localparam int ANGX_W     = ANG_W + 1;
  localparam int DEG_W      = ANGX_W - ANGLE_FRAC;
  localparam int OPD_W      = 36;
  localparam int CRD_W      = 46;
  localparam int NORM_MSB   = 40;
  localparam int MAG_W      = NORM_MSB + 1;
  localparam int NORM_STEPS = $clog2(NORM_MSB + 1);
  localparam int ATAN_LAT   = 1 + NORM_STEPS + CORDIC_STEPS;

  // pipeline timing, counted in register stages from the input register
  localparam int S_OPS    = 4;
  localparam int ATT_IN   = S_OPS + 2 + SQRT_STEPS;
  localparam int ATT_OUT  = ATT_IN + ATAN_LAT;
  localparam int HB_OUT   = S_OPS + ATAN_LAT;
  localparam int HB_DLY   = ATT_OUT - HB_OUT;
  localparam int HB_SIDE  = HB_OUT - S_OPS - 1;
  localparam int SIDE_DLY = ATT_OUT - S_OPS;
  localparam int V_DLY    = ATT_IN - S_OPS;
  localparam int PIPE_LAT = ATT_OUT + 1;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(16351);
  localparam logic signed [ANG_W-1:0] DEG90_Q = ANG_W'(90) <<< ANGLE_FRAC;
  localparam logic signed [ANGX_W-1:0] RND_HALF = ANGX_W'(1) <<< (ANGLE_FRAC - 1);

  typedef enum logic [POLE_W-1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_e;

  typedef struct packed {
    pole_e pole;
    logic  sat_pos;
    logic  sat_neg;
  } q2e_side_t;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [BANK_W-1:0] bank;
  } q2e_hb_t;

  // arctangent of 2^-i in degrees, 16 fraction bits, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
    logic signed [ANG_W-1:0] r;
    unique case (idx)
      0:  r = ANG_W'(2949120);
      1:  r = ANG_W'(1740967);
      2:  r = ANG_W'(919879);
      3:  r = ANG_W'(466945);
      4:  r = ANG_W'(234379);
      5:  r = ANG_W'(117304);
      6:  r = ANG_W'(58666);
      7:  r = ANG_W'(29335);
      8:  r = ANG_W'(14668);
      9:  r = ANG_W'(7334);
      10: r = ANG_W'(3667);
      11: r = ANG_W'(1833);
      12: r = ANG_W'(917);
      13: r = ANG_W'(458);
      14: r = ANG_W'(229);
      15: r = ANG_W'(115);
      16: r = ANG_W'(57);
      17: r = ANG_W'(29);
      18: r = ANG_W'(14);
      19: r = ANG_W'(7);
      20: r = ANG_W'(4);
      21: r = ANG_W'(2);
      22: r = ANG_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // whole degrees, half away from zero
  function automatic logic signed [DEG_W-1:0] round_deg(input logic signed [ANGX_W-1:0] a);
    logic signed [ANGX_W-1:0] t;
    t = a + (a[ANGX_W-1] ? (RND_HALF - ANGX_W'(1)) : RND_HALF);
    return t[ANGX_W-1:ANGLE_FRAC];
  endfunction

endpackage
`default_nettype wire

@@ sv/q2e_atan2.sv @@
`default_nettype none
// pipelined atan2 in degrees: quadrant fold, staged normalising shift,
// then one cordic vectoring step per stage; uses q2e_pkg
module q2e_atan2 import q2e_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [OPD_W-1:0] y_i,
  input  logic signed [OPD_W-1:0] x_i,
  output logic signed [ANG_W-1:0] ang_o
);

  localparam int STG = NORM_STEPS + CORDIC_STEPS + 1;

  logic signed [CRD_W-1:0] x_q [STG-1];
  logic signed [CRD_W-1:0] x_d [STG-1];
  logic signed [CRD_W-1:0] y_q [STG-1];
  logic signed [CRD_W-1:0] y_d [STG-1];
  logic signed [ANG_W-1:0] z_q [STG];
  logic signed [ANG_W-1:0] z_d [STG];
  logic                    zero_q [STG];
  logic                    zero_d [STG];
  logic [MAG_W-1:0]        m_q [NORM_STEPS];
  logic [MAG_W-1:0]        m_d [NORM_STEPS];

  always_comb begin
    logic signed [OPD_W-1:0] rx, ry;
    logic signed [ANG_W-1:0] rz;
    logic [OPD_W-1:0]        ax, ay;
    logic                    big, up;
    int                      sh, k;
    // fold the left half plane by a quarter turn
    if (x_i[OPD_W-1]) begin
      if (!y_i[OPD_W-1]) begin
        rx = y_i;
        ry = -x_i;
        rz = DEG90_Q;
      end else begin
        rx = -y_i;
        ry = x_i;
        rz = -DEG90_Q;
      end
    end else begin
      rx = x_i;
      ry = y_i;
      rz = '0;
    end
    ax = rx[OPD_W-1] ? -rx : rx;
    ay = ry[OPD_W-1] ? -ry : ry;
    x_d[0]    = CRD_W'(rx);
    y_d[0]    = CRD_W'(ry);
    z_d[0]    = rz;
    zero_d[0] = (x_i == '0) && (y_i == '0);
    m_d[0]    = MAG_W'(ax | ay);
    // binary normalising shift: 32, 16, ... 1
    for (int j = 0; j < NORM_STEPS; j++) begin
      sh  = 1 << (NORM_STEPS - 1 - j);
      big = (m_q[j] >> (MAG_W - sh)) != '0;
      x_d[j+1]    = big ? x_q[j] : (x_q[j] <<< sh);
      y_d[j+1]    = big ? y_q[j] : (y_q[j] <<< sh);
      z_d[j+1]    = z_q[j];
      zero_d[j+1] = zero_q[j];
      if (j + 1 < NORM_STEPS) begin
        m_d[j+1] = big ? m_q[j] : (m_q[j] << sh);
      end
    end
    // vectoring steps
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      k  = NORM_STEPS + i;
      up = !y_q[k][CRD_W-1] && (y_q[k] != '0);
      z_d[k+1]    = up ? (z_q[k] + atan_entry(i)) : (z_q[k] - atan_entry(i));
      zero_d[k+1] = zero_q[k];
      if (i + 1 < CORDIC_STEPS) begin
        x_d[k+1] = up ? (x_q[k] + (y_q[k] >>> i)) : (x_q[k] - (y_q[k] >>> i));
        y_d[k+1] = up ? (y_q[k] - (x_q[k] >>> i)) : (y_q[k] + (x_q[k] >>> i));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
    m_q    <= m_d;
  end

  assign ang_o = zero_q[STG-1] ? '0 : z_q[STG-1];

endmodule
`default_nettype wire

@@ sv/quaternion_to_euler_degrees.sv @@
`default_nettype none
// top level: quaternion (s, x, y, z) to bank, heading and attitude in degrees
// depends on q2e_pkg and q2e_atan2
//
// usage
// - input beat: drive scalar_part_i, vec_x_i, vec_y_i, vec_z_i and raise start;
//   the beat is taken at any rising edge with start high and busy low
// - busy stays low: a new quaternion may enter at every clock, one per cycle
// - result beat: done_o is high for exactly one cycle with bank_deg_o,
//   heading_deg_o, attitude_deg_o and pole_case_o; the receiver cannot stall
// - the 31-stage square root feeding the attitude cordic (23 stages) sets the
//   depth of the pipeline; heading and bank wait in a delay line so all three
//   leave together
// - pole bound: write channel cfg_valid_i / cfg_ready_o / cfg_pole_threshold_i,
//   always ready, to be changed only while no beat is in flight
// - reset clears the valid chain and loads the bound 0.499 (16351);
//   payload registers are not reset
// stages: input, products, sums, pole test, attitude square root, then per angle
// a quadrant fold, a staged normalising shift and one cordic step per stage
module quaternion_to_euler_degrees import q2e_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [COMP_W-1:0] scalar_part_i,
  input  logic signed [COMP_W-1:0] vec_x_i,
  input  logic signed [COMP_W-1:0] vec_y_i,
  input  logic signed [COMP_W-1:0] vec_z_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [THR_W-1:0]         cfg_pole_threshold_i,
  output logic                     done_o,
  output logic signed [BANK_W-1:0] bank_deg_o,
  output logic signed [HEAD_W-1:0] heading_deg_o,
  output logic signed [ATT_W-1:0]  attitude_deg_o,
  output logic [POLE_W-1:0]        pole_case_o
);

  localparam logic signed [OPD_W-1:0]  ONE_OPD = OPD_W'(1) <<< ONE_SHIFT;
  localparam logic signed [TEST_W:0]   ONE_V   = (TEST_W + 1)'(1) <<< ONE_SHIFT;
  localparam logic [RAD_W-1:0]         RAD_ONE = RAD_W'(1) << RAD_MSB;
  localparam logic signed [ATT_W-1:0]  ATT_90  = ATT_W'(90);

  logic                 accept;
  logic [THR_W-1:0]     thr_q;
  logic [PIPE_LAT-1:0]  vld_q;

  // input, product and sum stages
  logic signed [COMP_W-1:0] s1_s_q, s1_x_q, s1_y_q, s1_z_q;
  logic signed [PROD_W-1:0] p_xy_q, p_zs_q, p_ys_q, p_xz_q, p_yy_q, p_zz_q;
  logic signed [PROD_W-1:0] p_xx_q, p_xs_q, p_yz_q;
  logic signed [COMP_W-1:0] s2_s_q, s2_x_q, s3_s_q, s3_x_q;
  logic signed [TEST_W-1:0] s3_test_q;
  logic signed [OPD_W-1:0]  s3_hy_q, s3_hx_q, s3_by_q, s3_bx_q;

  // pole test stage
  logic signed [TEST_W+1:0] bound, test_x;
  logic signed [TEST_W:0]   v_w;
  logic                     north, south;
  q2e_side_t                side_d, s4_side_q;
  logic signed [OPD_W-1:0]  s4_hy_q, s4_hx_q, s4_by_q, s4_bx_q;
  logic signed [V_W-1:0]    s4_v_q;

  // attitude: square, radicand, bit-per-stage square root
  logic signed [2*V_W-1:0]             s5_sq_q;
  logic [RAD_W-1:0]                    s6_rad_q;
  logic [SQRT_STEPS-1:0][RAD_W-1:0]    rad_q, rad_d, root_q, root_d;
  logic [V_DLY-1:0][V_W-1:0]           v_dl_q;
  logic signed [OPD_W-1:0]             att_y, att_x;

  // angle units and alignment
  logic signed [ANG_W-1:0]        head_ang, bank_ang, att_ang;
  q2e_side_t [SIDE_DLY-1:0]       side_dl_q;
  q2e_side_t                      side_hb, side_out;
  q2e_hb_t                        hb_d;
  q2e_hb_t [HB_DLY-1:0]           hb_dl_q;
  logic signed [ANGX_W-1:0]       head_a;
  logic signed [DEG_W-1:0]        head_r, bank_r, att_r;
  logic signed [ATT_W-1:0]        att_d;

  logic signed [BANK_W-1:0] bank_q;
  logic signed [HEAD_W-1:0] head_q;
  logic signed [ATT_W-1:0]  att_q;
  pole_e                    pole_q;

  // no back-pressure anywhere: always open for input and configuration
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      vld_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_pole_threshold_i;
      end
      vld_q <= {vld_q[PIPE_LAT-2:0], accept};
    end
  end

  // stages 1 to 3: capture, nine products, then test and atan2 operands
  always_ff @(posedge clk_i) begin
    s1_s_q <= scalar_part_i;
    s1_x_q <= vec_x_i;
    s1_y_q <= vec_y_i;
    s1_z_q <= vec_z_i;

    p_xy_q <= s1_x_q * s1_y_q;
    p_zs_q <= s1_z_q * s1_s_q;
    p_ys_q <= s1_y_q * s1_s_q;
    p_xz_q <= s1_x_q * s1_z_q;
    p_yy_q <= s1_y_q * s1_y_q;
    p_zz_q <= s1_z_q * s1_z_q;
    p_xx_q <= s1_x_q * s1_x_q;
    p_xs_q <= s1_x_q * s1_s_q;
    p_yz_q <= s1_y_q * s1_z_q;
    s2_s_q <= s1_s_q;
    s2_x_q <= s1_x_q;

    s3_test_q <= TEST_W'(p_xy_q) + TEST_W'(p_zs_q);
    s3_hy_q   <= (OPD_W'(p_ys_q) - OPD_W'(p_xz_q)) <<< 1;
    s3_hx_q   <= ONE_OPD - ((OPD_W'(p_yy_q) + OPD_W'(p_zz_q)) <<< 1);
    s3_by_q   <= (OPD_W'(p_xs_q) - OPD_W'(p_yz_q)) <<< 1;
    s3_bx_q   <= ONE_OPD - ((OPD_W'(p_xx_q) + OPD_W'(p_zz_q)) <<< 1);
    s3_s_q    <= s2_s_q;
    s3_x_q    <= s2_x_q;
  end

  // stage 4: gimbal-lock test (strict on both sides) and asin range check
  always_comb begin
    bound  = (TEST_W + 2)'(thr_q) <<< FRAC_BITS;
    test_x = (TEST_W + 2)'(s3_test_q);
    north  = test_x > bound;
    south  = test_x < -bound;
    v_w    = (TEST_W + 1)'(s3_test_q) <<< 1;
    side_d.pole    = north ? POLE_NORTH : (south ? POLE_SOUTH : POLE_NONE);
    side_d.sat_pos = v_w >= ONE_V;
    side_d.sat_neg = v_w <= -ONE_V;
  end

  always_ff @(posedge clk_i) begin
    // at a pole the heading unit takes atan2(x, s) instead
    s4_hy_q   <= (north || south) ? OPD_W'(s3_x_q) : s3_hy_q;
    s4_hx_q   <= (north || south) ? OPD_W'(s3_s_q) : s3_hx_q;
    s4_by_q   <= s3_by_q;
    s4_bx_q   <= s3_bx_q;
    s4_v_q    <= v_w[V_W-1:0];
    s4_side_q <= side_d;
  end

  // attitude: cos term is floor(sqrt(2^60 - v^2)), one result bit per stage
  always_comb begin
    logic [RAD_W-1:0] n_in, r_in, trial, bitv;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        n_in = s6_rad_q;
        r_in = '0;
      end else begin
        n_in = rad_q[k-1];
        r_in = root_q[k-1];
      end
      bitv  = RAD_W'(1) << (RAD_MSB - 2 * k);
      trial = r_in + bitv;
      if (n_in >= trial) begin
        rad_d[k]  = n_in - trial;
        root_d[k] = (r_in >> 1) + bitv;
      end else begin
        rad_d[k]  = n_in;
        root_d[k] = r_in >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s5_sq_q   <= s4_v_q * s4_v_q;
    s6_rad_q  <= RAD_ONE - RAD_W'(s5_sq_q[RAD_MSB:0]);
    rad_q     <= rad_d;
    root_q    <= root_d;
    v_dl_q    <= {v_dl_q[V_DLY-2:0], s4_v_q};
    side_dl_q <= {side_dl_q[SIDE_DLY-2:0], s4_side_q};
  end

  assign att_y = OPD_W'($signed(v_dl_q[V_DLY-1]));
  assign att_x = OPD_W'(root_q[SQRT_STEPS-1][V_W-1:0]);

  q2e_atan2 u_head (
    .clk_i (clk_i),
    .y_i   (s4_hy_q),
    .x_i   (s4_hx_q),
    .ang_o (head_ang)
  );

  q2e_atan2 u_bank (
    .clk_i (clk_i),
    .y_i   (s4_by_q),
    .x_i   (s4_bx_q),
    .ang_o (bank_ang)
  );

  q2e_atan2 u_att (
    .clk_i (clk_i),
    .y_i   (att_y),
    .x_i   (att_x),
    .ang_o (att_ang)
  );

  // heading and bank finish early: pole fix, rounding, then wait for attitude
  always_comb begin
    side_hb = side_dl_q[HB_SIDE];
    unique case (side_hb.pole)
      POLE_NORTH: head_a = ANGX_W'(head_ang) <<< 1;
      POLE_SOUTH: head_a = -(ANGX_W'(head_ang) <<< 1);
      default:    head_a = ANGX_W'(head_ang);
    endcase
    head_r  = round_deg(head_a);
    bank_r  = round_deg(ANGX_W'(bank_ang));
    hb_d.head = head_r[HEAD_W-1:0];
    hb_d.bank = (side_hb.pole == POLE_NONE) ? bank_r[BANK_W-1:0] : '0;
  end

  // final stage: attitude from pole code, asin saturation or cordic
  always_comb begin
    side_out = side_dl_q[SIDE_DLY-1];
    att_r    = round_deg(ANGX_W'(att_ang));
    priority if (side_out.pole == POLE_NORTH) begin
      att_d = ATT_90;
    end else if (side_out.pole == POLE_SOUTH) begin
      att_d = -ATT_90;
    end else if (side_out.sat_pos) begin
      att_d = ATT_90;
    end else if (side_out.sat_neg) begin
      att_d = -ATT_90;
    end else begin
      att_d = att_r[ATT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    hb_dl_q <= {hb_dl_q[HB_DLY-2:0], hb_d};
    bank_q  <= hb_dl_q[HB_DLY-1].bank;
    head_q  <= hb_dl_q[HB_DLY-1].head;
    att_q   <= att_d;
    pole_q  <= side_out.pole;
  end

  assign done_o         = vld_q[PIPE_LAT-1];
  assign bank_deg_o     = bank_q;
  assign heading_deg_o  = head_q;
  assign attitude_deg_o = att_q;
  assign pole_case_o    = pole_q;

  // every accepted beat comes out after the fixed latency
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PIPE_LAT done_o)
    else $error("result beat missing after fixed latency");

  // bank is forced to zero at either pole
  a_pole_bank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (pole_case_o != POLE_NONE)) |-> (bank_deg_o == '0))
    else $error("bank not zero at a pole");

  // attitude is +90 at the north pole
  a_pole_att : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (pole_case_o == POLE_NORTH)) |-> (attitude_deg_o == ATT_90))
    else $error("north pole attitude not +90");

  // attitude stays within a quarter turn
  a_att_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((attitude_deg_o <= ATT_90) && (attitude_deg_o >= -ATT_90)))
    else $error("attitude out of range");

endmodule
`default_nettype wire

@@ tb/quaternion_to_euler_degrees_tb.sv @@
`default_nettype none
// self-checking bench for quaternion_to_euler_degrees: an angle predictor
// built on 64-bit integers checks every result beat in order
// depends on q2e_pkg and the converter rtl
module quaternion_to_euler_degrees_tb;
  import q2e_pkg::*;

  typedef struct {
    logic signed [COMP_W-1:0] s;
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } quat_t;

  typedef struct {
    logic signed [BANK_W-1:0] bank;
    logic signed [HEAD_W-1:0] head;
    logic signed [ATT_W-1:0]  att;
    pole_e                    pole;
  } euler_t;

  // arctangent of 2^-i in degrees, 16 fraction bits
  localparam longint ATAN_DEG_Q16 [0:15] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };
  localparam longint NORM_BOUND = 64'sd1 << 40;
  localparam longint UNIT_Q30   = 64'sd1 << 30;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [COMP_W-1:0] scalar_part_i = '0;
  logic signed [COMP_W-1:0] vec_x_i = '0;
  logic signed [COMP_W-1:0] vec_y_i = '0;
  logic signed [COMP_W-1:0] vec_z_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [THR_W-1:0] cfg_pole_threshold_i = '0;
  logic done_o;
  logic signed [BANK_W-1:0] bank_deg_o;
  logic signed [HEAD_W-1:0] heading_deg_o;
  logic signed [ATT_W-1:0]  attitude_deg_o;
  logic [POLE_W-1:0]        pole_case_o;

  quat_t  quat_pending_q[$];
  euler_t euler_expect_q[$];
  logic [THR_W-1:0] pole_bound = THR_RESET;
  int sender_idle_pct = 0;
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_north = 0;
  int n_south = 0;

  quaternion_to_euler_degrees dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .scalar_part_i        (scalar_part_i),
    .vec_x_i              (vec_x_i),
    .vec_y_i              (vec_y_i),
    .vec_z_i              (vec_z_i),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_pole_threshold_i (cfg_pole_threshold_i),
    .done_o               (done_o),
    .bank_deg_o           (bank_deg_o),
    .heading_deg_o        (heading_deg_o),
    .attitude_deg_o       (attitude_deg_o),
    .pole_case_o          (pole_case_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // vectoring cordic, angle in degrees with 16 fraction bits
  function automatic longint cordic_deg(input longint yi, input longint xi);
    longint xa, ya, za, nx, ny;
    xa = xi;
    ya = yi;
    za = 0;
    if (xa == 0 && ya == 0) return 0;
    // fold the left half plane by a quarter turn
    if (xa < 0) begin
      if (ya >= 0) begin
        nx = ya; ya = -xa; xa = nx; za = 64'sd90 <<< 16;
      end else begin
        nx = -ya; ya = xa; xa = nx; za = -(64'sd90 <<< 16);
      end
    end
    while ((xa < 0 ? -xa : xa) < NORM_BOUND && (ya < 0 ? -ya : ya) < NORM_BOUND) begin
      xa = xa * 2;
      ya = ya * 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (ya > 0) begin
        nx = xa + (ya >>> i); ny = ya - (xa >>> i); za = za + ATAN_DEG_Q16[i];
      end else begin
        nx = xa - (ya >>> i); ny = ya + (xa >>> i); za = za - ATAN_DEG_Q16[i];
      end
      xa = nx;
      ya = ny;
    end
    return za;
  endfunction

  function automatic longint whole_deg(input longint a);
    if (a >= 0) return (a + 32768) >>> 16;
    return -((-a + 32768) >>> 16);
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // asin of a q30 value, saturating at the unit circle
  function automatic longint asin_whole_deg(input longint v);
    longint c;
    if (v >= UNIT_Q30) return 90;
    if (v <= -UNIT_Q30) return -90;
    c = longint'(floor_sqrt((64'd1 << 60) - longint'(v * v)));
    return whole_deg(cordic_deg(v, c));
  endfunction

  function automatic euler_t predict_euler(input quat_t q, input logic [THR_W-1:0] bound);
    longint s, x, y, z, test, lim;
    euler_t r;
    s = q.s; x = q.x; y = q.y; z = q.z;
    test = x * y + z * s;
    lim = longint'(bound) <<< FRAC_BITS;
    if (test > lim) begin
      r.head = HEAD_W'(whole_deg(2 * cordic_deg(x, s)));
      r.att  = ATT_W'(90);
      r.bank = '0;
      r.pole = POLE_NORTH;
    end else if (test < -lim) begin
      r.head = HEAD_W'(whole_deg(-2 * cordic_deg(x, s)));
      r.att  = -ATT_W'(90);
      r.bank = '0;
      r.pole = POLE_SOUTH;
    end else begin
      r.head = HEAD_W'(whole_deg(cordic_deg(2 * (y * s - x * z), UNIT_Q30 - 2 * (y * y + z * z))));
      r.att  = ATT_W'(asin_whole_deg(2 * test));
      r.bank = BANK_W'(whole_deg(cordic_deg(2 * (x * s - y * z), UNIT_Q30 - 2 * (x * x + z * z))));
      r.pole = POLE_NONE;
    end
    return r;
  endfunction

  // driver: new beat or idle at every falling edge
  always @(negedge clk_i) begin
    if (rst_ni && quat_pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
      start         <= 1'b1;
      scalar_part_i <= quat_pending_q[0].s;
      vec_x_i       <= quat_pending_q[0].x;
      vec_y_i       <= quat_pending_q[0].y;
      vec_z_i       <= quat_pending_q[0].z;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: accepted input beats become expectations, result beats are checked
  always @(posedge clk_i) begin
    euler_t exp_r;
    if (rst_ni && start && !busy && quat_pending_q.size() != 0) begin
      exp_r = predict_euler(quat_pending_q.pop_front(), pole_bound);
      euler_expect_q.push_back(exp_r);
      n_sent++;
    end
    if (rst_ni && done_o) begin
      if (euler_expect_q.size() == 0) begin
        $error("result beat with nothing expected");
        n_errors++;
      end else begin
        exp_r = euler_expect_q.pop_front();
        n_checked++;
        if (exp_r.pole == POLE_NORTH) n_north++;
        if (exp_r.pole == POLE_SOUTH) n_south++;
        if (bank_deg_o !== exp_r.bank) begin
          $error("bank_deg expected %0d got %0d", exp_r.bank, bank_deg_o);
          n_errors++;
        end
        if (heading_deg_o !== exp_r.head) begin
          $error("heading_deg expected %0d got %0d", exp_r.head, heading_deg_o);
          n_errors++;
        end
        if (attitude_deg_o !== exp_r.att) begin
          $error("attitude_deg expected %0d got %0d", exp_r.att, attitude_deg_o);
          n_errors++;
        end
        if (pole_case_o !== exp_r.pole) begin
          $error("pole_case expected %0d got %0d", exp_r.pole, pole_case_o);
          n_errors++;
        end
      end
    end
  end

  task automatic push_quat(input int s, input int x, input int y, input int z);
    quat_t q;
    q.s = COMP_W'(s); q.x = COMP_W'(x); q.y = COMP_W'(y); q.z = COMP_W'(z);
    quat_pending_q.push_back(q);
  endtask

  // let every beat in flight come out, so the bound may be changed
  task automatic drain_pipe();
    wait (quat_pending_q.size() == 0 && euler_expect_q.size() == 0);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  task automatic write_bound(input logic [THR_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i          <= 1'b1;
    cfg_pole_threshold_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    pole_bound = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // items sitting exactly on and just past the gimbal-lock bound
  task automatic push_bound_edges(input int thr);
    push_quat(thr, 0, 0, -32768);           // test equals minus the bound
    push_quat(0, -32768, -thr, 0);          // test equals the bound
    if (thr < 32767) begin
      push_quat(0, -32768, -(thr + 1), 0);  // just north
      push_quat(thr + 1, 0, 0, -32768);     // just south
    end
  endtask

  // mostly unit quaternions, some close to the poles, some raw noise
  task automatic push_random(input int n);
    real a, b, c, d, nrm;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(9);
      if (sel < 5) begin
        a = real'($urandom_range(20000)) - 10000.0;
        b = real'($urandom_range(20000)) - 10000.0;
        c = real'($urandom_range(20000)) - 10000.0;
        d = real'($urandom_range(20000)) - 10000.0;
        nrm = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
        push_quat(int'(a / nrm * 32767.0), int'(b / nrm * 32767.0),
                  int'(c / nrm * 32767.0), int'(d / nrm * 32767.0));
      end else if (sel < 8) begin
        // near gimbal lock: x*y + z*s close to plus or minus one half
        a = ($urandom_range(1) ? 16384.0 : -16384.0);
        b = ($urandom_range(1) ? 1.0 : -1.0);
        push_quat(int'(a) + $urandom_range(300) - 150, int'(a) + $urandom_range(300) - 150,
                  int'(a * b) + $urandom_range(300) - 150, int'(a * b) + $urandom_range(300) - 150);
      end else begin
        push_quat($signed(16'($urandom)), $signed(16'($urandom)),
                  $signed(16'($urandom)), $signed(16'($urandom)));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part with the reset bound
    sender_idle_pct = 23;
    push_quat(32767, 0, 0, 0);
    push_quat(-32768, 0, 0, 0);           // negative scalar, heading from atan2 on the positive axis
    push_quat(0, 0, 0, 0);                // all four components zero
    push_quat(-32768, -32768, -32768, -32768);
    push_quat(32767, 32767, 32767, 32767);
    push_quat(0, 32767, 32767, 0);
    push_quat(0, 32767, -32768, 0);
    push_quat(16384, 16384, 16384, 16384);
    push_quat(16384, 16384, -16384, -16384);
    push_quat(-16384, 0, 0, 16384);
    push_quat(0, -32768, 0, 0);
    push_quat(0, 0, -32768, 0);
    push_quat(0, 0, 0, 32767);
    push_quat(23170, 0, 0, 23170);        // north pole, asin argument just below one
    push_quat(-21, 5, -32768, 1);
    push_bound_edges(16351);
    push_random(250);
    drain_pipe();

    sender_idle_pct = 88;
    write_bound(15'd0);
    push_bound_edges(0);
    push_random(200);
    drain_pipe();

    sender_idle_pct = 0;
    write_bound(15'd32767);
    push_bound_edges(32767);
    push_random(250);
    drain_pipe();

    sender_idle_pct = 23;
    write_bound(15'd16384);
    push_bound_edges(16384);
    push_random(250);
    drain_pipe();

    sender_idle_pct = 0;
    write_bound(15'd16351);
    push_random(230);
    drain_pipe();

    $display("%0d quaternions sent, %0d results checked over five pole bounds",
             n_sent, n_checked);
    $display("%0d north and %0d south singularities among them", n_north, n_south);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire

@@ quaternion_to_euler_degrees.f @@
sv/q2e_pkg.sv
sv/q2e_atan2.sv
sv/quaternion_to_euler_degrees.sv
tb/quaternion_to_euler_degrees_tb.sv
